/* design/lz78_pkg.sv */
package lz78_pkg;

  // Alphabet: letters, digits and nine punctuation codes, plus the end sentinel
  localparam int NUM_SYMBOLS = 62 + 9;
  localparam int SYM_W       = 7;
  localparam int END_SYM     = NUM_SYMBOLS;
  localparam int COLUMNS     = NUM_SYMBOLS + 1;

  // Default dictionary geometry
  localparam int MAX_PHRASES_DEF = 4096;
  localparam int INDEX_BITS_DEF  = 12;

  typedef struct packed {
    logic             ok;
    logic [SYM_W-1:0] sym;
  } sym_map_t;

  // Map a raw byte to its symbol; ok is low for unsupported bytes
  function automatic sym_map_t sym_of(input logic [7:0] b);
    sym_map_t m;
    m.ok  = 1'b1;
    m.sym = '0;
    if (b >= 8'h61 && b <= 8'h7A) begin         // 'a'..'z'
      m.sym = SYM_W'(b - 8'h61);
    end else if (b >= 8'h41 && b <= 8'h5A) begin  // 'A'..'Z'
      m.sym = SYM_W'(b - 8'h41) + SYM_W'(26);
    end else if (b >= 8'h30 && b <= 8'h39) begin  // '0'..'9'
      m.sym = SYM_W'(b - 8'h30) + SYM_W'(52);
    end else begin
      unique case (b)
        8'h3F:   m.sym = SYM_W'(62);  // '?'
        8'h21:   m.sym = SYM_W'(63);  // '!'
        8'h20:   m.sym = SYM_W'(64);  // space
        8'h2E:   m.sym = SYM_W'(65);  // '.'
        8'h2C:   m.sym = SYM_W'(66);  // ','
        8'h3A:   m.sym = SYM_W'(67);  // ':'
        8'h3B:   m.sym = SYM_W'(68);  // ';'
        8'h0A:   m.sym = SYM_W'(69);  // line feed
        8'h0D:   m.sym = SYM_W'(70);  // carriage return
        default: m.ok  = 1'b0;
      endcase
    end
    return m;
  endfunction

endpackage

/* design/lz78_trie_encoder.sv */
// Channel | Dir | Ports                                   | Contents
// in_     | in  | in_tvalid in_tready in_tdata in_tuser    | raw byte, end-of-input flag
// out_    | out | out_tvalid out_tready out_tdata out_tlast | packed stream byte, run end,
//         |     | out_tuser                               | end of stream
//
// A symbol item passes S_IDLE (child-table read), then S_LOOK (compare and write
// back); an unsupported byte or an item after the end stays in S_IDLE. A miss
// appends up to INDEX_BITS+7 bits and the next item waits until fewer than 8
// remain, one output byte draining per cycle while the output is not stalled.
// After reset a clearing pass writes all capacity*72 child-table entries with
// in_tready low. A stalled output holds its byte; items after the end drop.
module lz78_trie_encoder #(
  parameter int MAX_PHRASES = lz78_pkg::MAX_PHRASES_DEF,
  parameter int INDEX_BITS  = lz78_pkg::INDEX_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic       in_tuser,   // [0] kind (1 = end of input)
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic       out_tlast,  // last_of_run
  output logic       out_tuser   // [0] end_of_stream
);

  localparam int SYM_W  = lz78_pkg::SYM_W;
  localparam int CAP    = (MAX_PHRASES < (1 << INDEX_BITS)) ? MAX_PHRASES
                                                            : (1 << INDEX_BITS);
  localparam int DEPTH  = CAP * lz78_pkg::COLUMNS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int NODE_W = INDEX_BITS;
  localparam int NP_W   = $clog2(CAP + 1);
  localparam int IW_W   = $clog2(INDEX_BITS + 1);
  localparam int PW_W   = INDEX_BITS + 1;
  localparam int ACC_W  = INDEX_BITS + 2 * SYM_W;
  localparam int CNT_W  = $clog2(ACC_W + 1);

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_LOOK} state_t;

  state_t             state_r, state_nxt;
  logic [ADDR_W-1:0]  clr_addr_r, clr_addr_nxt;
  logic [NODE_W-1:0]  match_node_r, match_node_nxt;
  logic [NP_W-1:0]    np_r, np_nxt;
  logic [IW_W-1:0]    iw_r, iw_nxt;
  logic [ACC_W-1:0]   acc_r, acc_nxt;
  logic [CNT_W-1:0]   acc_cnt_r, acc_cnt_nxt;
  logic               flush_r, flush_nxt;
  logic               finished_r, finished_nxt;
  logic [SYM_W-1:0]   sym_r, sym_nxt;
  logic               is_end_r, is_end_nxt;
  logic [ADDR_W-1:0]  addr_r, addr_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [7:0]         out_data_r, out_data_nxt;
  logic               out_last_r, out_last_nxt;
  logic               out_eos_r, out_eos_nxt;

  // Child table
  logic [NODE_W-1:0]  child_mem [DEPTH];
  logic [NODE_W-1:0]  rd_data_r;
  logic [ADDR_W-1:0]  rd_addr;
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr;
  logic [NODE_W-1:0]  mem_wdata;

  lz78_pkg::sym_map_t in_sym;
  logic               in_xfer;
  logic [NP_W-1:0]    np_inc;
  logic [PW_W-1:0]    width_pow;
  logic [CNT_W-1:0]   cnt_left;
  logic               drain_go;

  assign in_sym    = lz78_pkg::sym_of(in_tdata);
  assign in_tready = (state_r == S_IDLE) && (acc_cnt_r < CNT_W'(8)) && !flush_r;
  assign in_xfer   = in_tvalid && in_tready;
  assign rd_addr   = ADDR_W'(match_node_r) * ADDR_W'(lz78_pkg::COLUMNS)
                   + ADDR_W'(in_sym.sym);
  assign np_inc    = np_r + NP_W'(1);
  assign width_pow = PW_W'(1) << iw_r;
  assign cnt_left  = (acc_cnt_r >= CNT_W'(8)) ? (acc_cnt_r - CNT_W'(8)) : '0;
  assign drain_go  = (!out_valid_r || out_tready)
                   && ((acc_cnt_r >= CNT_W'(8)) || (flush_r && acc_cnt_r != '0));

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      child_mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= child_mem[rd_addr];
  end

  // Next-state logic: clear sweep, lookup, token append, byte drain
  always_comb begin
    state_nxt      = state_r;
    clr_addr_nxt   = clr_addr_r;
    match_node_nxt = match_node_r;
    np_nxt         = np_r;
    iw_nxt         = iw_r;
    acc_nxt        = acc_r;
    acc_cnt_nxt    = acc_cnt_r;
    flush_nxt      = flush_r;
    finished_nxt   = finished_r;
    sym_nxt        = sym_r;
    is_end_nxt     = is_end_r;
    addr_nxt       = addr_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    out_last_nxt   = out_last_r;
    out_eos_nxt    = out_eos_r;
    mem_we         = 1'b0;
    mem_waddr      = addr_r;
    mem_wdata      = NODE_W'(np_r);

    unique case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr_r;
        mem_wdata = '0;
        clr_addr_nxt = clr_addr_r + ADDR_W'(1);
        if (clr_addr_r == ADDR_W'(DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        // Take an item; drop it after the end or when its byte has no symbol
        if (in_xfer && !finished_r) begin
          if (in_tuser) begin
            is_end_nxt = 1'b1;
            sym_nxt    = SYM_W'(lz78_pkg::END_SYM);
            addr_nxt   = ADDR_W'(match_node_r) * ADDR_W'(lz78_pkg::COLUMNS)
                       + ADDR_W'(lz78_pkg::END_SYM);
            state_nxt  = S_LOOK;
          end else if (in_sym.ok) begin
            is_end_nxt = 1'b0;
            sym_nxt    = in_sym.sym;
            addr_nxt   = rd_addr;
            state_nxt  = S_LOOK;
          end
        end
      end
      S_LOOK: begin
        state_nxt = S_IDLE;
        if (!is_end_r && rd_data_r != '0) begin
          match_node_nxt = rd_data_r;
        end else begin
          // Append node index then symbol, LSB first
          acc_nxt = acc_r | (ACC_W'(match_node_r) << acc_cnt_r)
                          | (ACC_W'(sym_r) << (acc_cnt_r + CNT_W'(iw_r)));
          acc_cnt_nxt = acc_cnt_r + CNT_W'(iw_r) + CNT_W'(SYM_W);
          if (np_r < NP_W'(CAP)) begin
            mem_we = 1'b1;
            np_nxt = np_inc;
            if (iw_r < IW_W'(INDEX_BITS) && PW_W'(np_inc) == width_pow) begin
              iw_nxt = iw_r + IW_W'(1);
            end
          end
          match_node_nxt = '0;
          if (is_end_r) begin
            finished_nxt = 1'b1;
            flush_nxt    = 1'b1;
          end
        end
      end
      default: state_nxt = S_CLEAR;
    endcase

    // Output register: take the next byte when empty or being taken
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (drain_go) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = acc_r[7:0];
      acc_nxt       = acc_r >> 8;
      acc_cnt_nxt   = cnt_left;
      out_last_nxt  = flush_r ? (cnt_left == '0) : (cnt_left < CNT_W'(8));
      out_eos_nxt   = flush_r && (cnt_left == '0);
      if (flush_r && cnt_left == '0) begin
        flush_nxt = 1'b0;
      end
    end
  end

  // Hold state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_addr_r   <= '0;
      match_node_r <= '0;
      np_r         <= NP_W'(1);
      iw_r         <= IW_W'(1);
      acc_r        <= '0;
      acc_cnt_r    <= '0;
      flush_r      <= 1'b0;
      finished_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_addr_r   <= clr_addr_nxt;
      match_node_r <= match_node_nxt;
      np_r         <= np_nxt;
      iw_r         <= iw_nxt;
      acc_r        <= acc_nxt;
      acc_cnt_r    <= acc_cnt_nxt;
      flush_r      <= flush_nxt;
      finished_r   <= finished_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    sym_r      <= sym_nxt;
    is_end_r   <= is_end_nxt;
    addr_r     <= addr_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
    out_eos_r  <= out_eos_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_eos_r;

endmodule

/* design/lz78_checker.sv */
module lz78_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast,
  input logic       out_tuser
);

  // Input held off right after reset while the table clears
  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_tready)
    else $error("in_tready high right after reset");

  // End of stream always closes a run
  a_eos_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> out_tlast)
    else $error("end of stream without last of run");

  // Nothing follows the final byte
  a_quiet_after_eos: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tuser) |=> !out_tvalid)
    else $error("output after end of stream");

  // Stalled output byte holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)
                                     && $stable(out_tlast) && $stable(out_tuser)))
    else $error("stalled output changed");

endmodule

bind lz78_trie_encoder lz78_checker u_lz78_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);
